// File: rtl/core/pnu_pkg.sv
// shared types and constants for the plant nitrogen uptake block
// used by every module under rtl/core except pnu_div; depends on nothing
package pnu_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_AMMONIUM       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_NITRATE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ORGANIC        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_AMMONIUM        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_NITRATE         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ORGANIC         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AMMONIUM_EFFECT_GAIN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_AMMONIUM_EFFECT_HALF = 3'd7;

  localparam logic [15:0] CFG_RESET = 16'd256;

  // default moisture half-saturation levels, q8.8
  localparam int MOIST_HALF_AMMONIUM = 128;
  localparam int MOIST_HALF_NITRATE  = 128;
  localparam int MOIST_HALF_ORGANIC  = 128;

  // temperature offset of 20 degrees and divisor 55 * 256, q8.8
  localparam int TEMP_OFFSET = 5120;
  localparam int TEMP_DIV    = 14080;

  // hill ratio lanes and their latency
  localparam int HILL_W   = 17;
  localparam int HILL_QW  = 17;
  localparam int HILL_LAT = 2 * HILL_QW + 6;
  localparam int NUM_LANES = 7;

  localparam int LANE_HC_AMM = 0;
  localparam int LANE_HC_NIT = 1;
  localparam int LANE_HC_ORG = 2;
  localparam int LANE_HW_AMM = 3;
  localparam int LANE_HW_NIT = 4;
  localparam int LANE_HW_ORG = 5;
  localparam int LANE_HE     = 6;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic [15:0]        moisture;
    logic [15:0]        ammonium_level;
    logic [15:0]        nitrate_level;
    logic [15:0]        organic_level;
    logic [15:0]        demand_scale;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] total_to_plant;
    logic signed [31:0] ammonium_used;
    logic signed [31:0] nitrate_used;
    logic signed [31:0] organic_used;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] limit_ammonium;
    logic [15:0] limit_nitrate;
    logic [15:0] limit_organic;
    logic [15:0] gain_ammonium;
    logic [15:0] gain_nitrate;
    logic [15:0] gain_organic;
    logic [15:0] ammonium_effect_gain;
    logic [15:0] ammonium_effect_half;
  } cfg_regs_t;

  typedef struct packed {
    logic [HILL_W-1:0] hc_amm;
    logic [HILL_W-1:0] hc_nit;
    logic [HILL_W-1:0] hc_org;
    logic [HILL_W-1:0] hw_amm;
    logic [HILL_W-1:0] hw_nit;
    logic [HILL_W-1:0] hw_org;
    logic [HILL_W-1:0] he;
  } hill_set_t;

  // per-item values that ride alongside the hill lanes
  typedef struct packed {
    logic        valid;
    logic        neg;
    logic [15:0] mag;
    logic [15:0] demand;
  } side_t;

endpackage

// File: rtl/core/pnu_div.sv
// pipelined restoring divider, one quotient bit per stage
// standalone; used by pnu_hill
module pnu_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 17,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem  [QW+1];
  logic [DW-1:0] dv   [QW+1];
  logic [QW-1:0] qp   [QW+1];
  logic [SW-1:0] side [QW+1];

  assign rem[0]  = num;
  assign dv[0]   = den;
  assign qp[0]   = '0;
  assign side[0] = side_in;

  // one trial subtract per stage, most significant bit first
  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [CW-1:0] trial;
    logic [CW-1:0] remx;
    logic          hit;

    assign trial = CW'(dv[k]) << B;
    assign remx  = CW'(rem[k]);
    assign hit   = remx >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= hit ? NW'(remx - trial) : rem[k];
        dv[k+1]  <= dv[k];
        qp[k+1]  <= qp[k] | (QW'(hit) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        side[k+1] <= '0;
      end else if (en) begin
        side[k+1] <= side[k];
      end
    end
  end

  assign quo      = qp[QW];
  assign side_out = side[QW];

endmodule

// File: rtl/core/pnu_hill.sv
// one lane: eighth-order hill ratio x^8 / (k^8 + x^8) in q1.16
// depends on pnu_pkg and pnu_div
module pnu_hill (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [15:0]                 x,
  input  logic [15:0]                 k,
  output logic [pnu_pkg::HILL_W-1:0]  ratio
);

  localparam int W = pnu_pkg::HILL_W;

  // order the operands
  logic [15:0] mn;
  logic [15:0] mx;
  logic        xge;
  logic        xz;

  always_ff @(posedge clk) begin
    if (en) begin
      xge <= x >= k;
      xz  <= x == 16'd0;
      mn  <= (x >= k) ? k : x;
      mx  <= (x >= k) ? x : k;
    end
  end

  // r = min * 2^16 / max
  logic [W-1:0] r;
  logic [1:0]   fl_r;

  pnu_div #(.NW(32), .DW(16), .QW(pnu_pkg::HILL_QW), .SW(2)) u_div_r (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .num     ({mn, 16'h0000}),
    .den     (mx),
    .side_in ({xz, xge}),
    .quo     (r),
    .side_out(fl_r)
  );

  // r^8 by three registered squarings
  logic [W-1:0] sq [4];
  logic [1:0]   fl [4];

  assign sq[0] = r;
  assign fl[0] = fl_r;

  for (genvar s = 0; s < 3; s++) begin : g_sq
    logic [2*W-1:0] p;
    assign p = (2*W)'(sq[s]) * (2*W)'(sq[s]);
    always_ff @(posedge clk) begin
      if (en) begin
        sq[s+1] <= p[W+15:16];
        fl[s+1] <= fl[s];
      end
    end
  end

  // operands of the final division
  logic [32:0] num2;
  logic [17:0] den2;
  logic        xz2;

  always_ff @(posedge clk) begin
    if (en) begin
      num2 <= fl[3][0] ? 33'h1_0000_0000 : {sq[3][16:0], 16'h0000};
      den2 <= 18'(sq[3]) + 18'd65536;
      xz2  <= fl[3][1];
    end
  end

  logic [W-1:0] q2;
  logic         xz3;

  pnu_div #(.NW(33), .DW(18), .QW(pnu_pkg::HILL_QW), .SW(1)) u_div_h (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .num     (num2),
    .den     (den2),
    .side_in (xz2),
    .quo     (q2),
    .side_out(xz3)
  );

  // zero level gives zero, 0/0 included
  always_ff @(posedge clk) begin
    if (en) begin
      ratio <= xz3 ? '0 : q2;
    end
  end

endmodule

// File: rtl/core/pnu_merge.sv
// merging stage: product chain, temperature scaling, sum and saturation
// depends on pnu_pkg
module pnu_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  pnu_pkg::cfg_regs_t  cfg,
  input  pnu_pkg::hill_set_t  hill,
  input  pnu_pkg::side_t      side,
  output logic                valid,
  output pnu_pkg::out_beat_t  beat
);

  localparam int DIG = 6;
  localparam int QW  = 8 * DIG;

  // stage 1: gain times concentration ratio
  logic [32:0] m1a, m1n, m1o, m1e;
  assign m1a = 33'(cfg.gain_ammonium) * 33'(hill.hc_amm);
  assign m1n = 33'(cfg.gain_nitrate) * 33'(hill.hc_nit);
  assign m1o = 33'(cfg.gain_organic) * 33'(hill.hc_org);
  assign m1e = 33'(cfg.ammonium_effect_gain) * 33'(hill.he);

  logic [23:0] p1a, p1n, p1o, e1;
  logic [16:0] w1a, w1n, w1o;
  pnu_pkg::side_t sd1, sd2, sd3, sd4, sd5;

  always_ff @(posedge clk) begin
    if (en) begin
      p1a <= m1a[31:8];
      p1n <= m1n[31:8];
      p1o <= m1o[31:8];
      e1  <= m1e[31:8];
      w1a <= hill.hw_amm;
      w1n <= hill.hw_nit;
      w1o <= hill.hw_org;
    end
  end

  // stage 2: times moisture ratio
  logic [40:0] m2a, m2n, m2o;
  assign m2a = 41'(p1a) * 41'(w1a);
  assign m2n = 41'(p1n) * 41'(w1n);
  assign m2o = 41'(p1o) * 41'(w1o);

  logic [23:0] u2a, u2n, u2o, e2;

  always_ff @(posedge clk) begin
    if (en) begin
      u2a <= m2a[39:16];
      u2n <= m2n[39:16];
      u2o <= m2o[39:16];
      e2  <= e1;
    end
  end

  // stage 3: nitrate scaled by the ammonium effect
  logic [47:0] m3n;
  assign m3n = 48'(u2n) * 48'(e2);

  logic [31:0] u3a, u3n, u3o;

  always_ff @(posedge clk) begin
    if (en) begin
      u3a <= 32'(u2a);
      u3n <= m3n[47:16];
      u3o <= 32'(u2o);
    end
  end

  // stage 4: times demand
  logic [47:0] m4a, m4n, m4o;
  assign m4a = 48'(u3a) * 48'(sd3.demand);
  assign m4n = 48'(u3n) * 48'(sd3.demand);
  assign m4o = 48'(u3o) * 48'(sd3.demand);

  logic [39:0] v4a, v4n, v4o;

  always_ff @(posedge clk) begin
    if (en) begin
      v4a <= m4a[47:8];
      v4n <= m4n[47:8];
      v4o <= m4o[47:8];
    end
  end

  // stage 5: times temperature magnitude
  logic [55:0] w5a, w5n, w5o;

  always_ff @(posedge clk) begin
    if (en) begin
      w5a <= 56'(v4a) * 56'(sd4.mag);
      w5n <= 56'(v4n) * 56'(sd4.mag);
      w5o <= 56'(v4o) * 56'(sd4.mag);
    end
  end

  // side values follow the product chain
  always_ff @(posedge clk) begin
    if (rst) begin
      sd1 <= '0;
      sd2 <= '0;
      sd3 <= '0;
      sd4 <= '0;
      sd5 <= '0;
    end else if (en) begin
      sd1 <= side;
      sd2 <= sd1;
      sd3 <= sd2;
      sd4 <= sd3;
      sd5 <= sd4;
    end
  end

  // quotient digit of x / 55 for x below 55 * 256, by reciprocal multiply
  function automatic logic [7:0] div55(input logic [13:0] x);
    logic [28:0] p;
    p = 29'(x) * 29'd19066;
    return p[27:20];
  endfunction

  // divide by 55 * 256: drop the low byte, then long division by 55,
  // one base-256 digit per stage
  logic [QW-1:0] dn  [3];
  logic [QW-1:0] quo [3];

  assign dn[0] = w5a[55:8];
  assign dn[1] = w5n[55:8];
  assign dn[2] = w5o[55:8];

  for (genvar l = 0; l < 3; l++) begin : g_div
    logic [QW-1:0] num [DIG+1];
    logic [QW-1:0] qt  [DIG+1];
    logic [5:0]    rm  [DIG+1];

    assign num[0] = dn[l];
    assign qt[0]  = '0;
    assign rm[0]  = '0;

    for (genvar k = 0; k < DIG; k++) begin : g_dig
      localparam int P = 8 * (DIG - 1 - k);
      logic [13:0] x;
      logic [7:0]  d;

      assign x = {rm[k], num[k][P +: 8]};
      assign d = div55(x);

      always_ff @(posedge clk) begin
        if (en) begin
          num[k+1] <= num[k];
          qt[k+1]  <= qt[k] | (QW'(d) << P);
          rm[k+1]  <= 6'(x - 14'(d) * 14'd55);
        end
      end
    end

    assign quo[l] = qt[DIG];
  end

  // valid and sign wait out the digit stages
  logic [1:0] vn [DIG];
  logic [1:0] vn_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIG; i++) vn[i] <= '0;
    end else if (en) begin
      vn[0] <= {sd5.valid, sd5.neg};
      for (int i = 1; i < DIG; i++) vn[i] <= vn[i-1];
    end
  end

  assign vn_d = vn[DIG-1];

  // restore the sign of t + 20
  logic signed [47:0] ra, rn, ro;
  logic               v6;

  always_ff @(posedge clk) begin
    if (en) begin
      ra <= vn_d[0] ? -$signed(quo[0]) : $signed(quo[0]);
      rn <= vn_d[0] ? -$signed(quo[1]) : $signed(quo[1]);
      ro <= vn_d[0] ? -$signed(quo[2]) : $signed(quo[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= vn_d[1];
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] res;
    if (v > 48'sd2147483647) begin
      res = 32'sh7fff_ffff;
    end else if (v < -48'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  logic signed [47:0] sum;
  assign sum = ra + rn + ro;

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      beat.total_to_plant <= sat32(sum);
      beat.ammonium_used  <= sat32(ra);
      beat.nitrate_used   <= sat32(rn);
      beat.organic_used   <= sat32(ro);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= v6;
    end
  end

endmodule

// File: rtl/core/plant_nitrogen_uptake.sv
// top level of the plant nitrogen uptake block: config registers, hill lanes, merge
// depends on pnu_pkg, pnu_hill, pnu_merge (and pnu_div below them)
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------
//   in       | in_valid / in_stall    | in_data  (pnu_pkg::in_beat_t)
//   out      | out_valid / out_stall  | out_data (pnu_pkg::out_beat_t)
//   cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one beat is accepted every cycle while the pipeline is not held; a result passes
// through the hill lanes (two 17-stage dividers, three squarings) and then the merge
// (five product stages, six digit stages dividing by 55 * 256, sign and saturation).
// rst is synchronous and clears the valid bits and the config registers to 1.0.
// the whole pipeline holds while a result waits on out_stall; cfg_ready is always high.
module plant_nitrogen_uptake #(
  parameter int MOIST_HALF_AMMONIUM = pnu_pkg::MOIST_HALF_AMMONIUM,
  parameter int MOIST_HALF_NITRATE  = pnu_pkg::MOIST_HALF_NITRATE,
  parameter int MOIST_HALF_ORGANIC  = pnu_pkg::MOIST_HALF_ORGANIC
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  pnu_pkg::in_beat_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output pnu_pkg::out_beat_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pnu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                       cfg_data
);

  localparam int LAT = pnu_pkg::HILL_LAT;

  logic en;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // configuration registers
  pnu_pkg::cfg_regs_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= {8{pnu_pkg::CFG_RESET}};
    end else if (cfg_valid) begin
      case (cfg_index)
        pnu_pkg::REG_LIMIT_AMMONIUM:       cfg.limit_ammonium       <= cfg_data;
        pnu_pkg::REG_LIMIT_NITRATE:        cfg.limit_nitrate        <= cfg_data;
        pnu_pkg::REG_LIMIT_ORGANIC:        cfg.limit_organic        <= cfg_data;
        pnu_pkg::REG_GAIN_AMMONIUM:        cfg.gain_ammonium        <= cfg_data;
        pnu_pkg::REG_GAIN_NITRATE:         cfg.gain_nitrate         <= cfg_data;
        pnu_pkg::REG_GAIN_ORGANIC:         cfg.gain_organic         <= cfg_data;
        pnu_pkg::REG_AMMONIUM_EFFECT_GAIN: cfg.ammonium_effect_gain <= cfg_data;
        pnu_pkg::REG_AMMONIUM_EFFECT_HALF: cfg.ammonium_effect_half <= cfg_data;
        default: ;
      endcase
    end
  end

  // temperature term t + 20 as sign and magnitude
  logic signed [16:0] tnum;
  pnu_pkg::side_t     side_in;

  assign tnum           = 17'(in_data.temperature) + 17'sd5120;
  assign side_in.valid  = in_valid;
  assign side_in.neg    = tnum[16];
  assign side_in.mag    = tnum[16] ? 16'(-tnum) : 16'(tnum);
  assign side_in.demand = in_data.demand_scale;

  // side values wait out the hill lanes
  pnu_pkg::side_t side_d [LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) side_d[i] <= '0;
    end else if (en) begin
      side_d[0] <= side_in;
      for (int i = 1; i < LAT; i++) side_d[i] <= side_d[i-1];
    end
  end

  // hill lanes
  logic [15:0]                lx [pnu_pkg::NUM_LANES];
  logic [15:0]                lk [pnu_pkg::NUM_LANES];
  logic [pnu_pkg::HILL_W-1:0] lh [pnu_pkg::NUM_LANES];

  assign lx[pnu_pkg::LANE_HC_AMM] = in_data.ammonium_level;
  assign lk[pnu_pkg::LANE_HC_AMM] = cfg.limit_ammonium;
  assign lx[pnu_pkg::LANE_HC_NIT] = in_data.nitrate_level;
  assign lk[pnu_pkg::LANE_HC_NIT] = cfg.limit_nitrate;
  assign lx[pnu_pkg::LANE_HC_ORG] = in_data.organic_level;
  assign lk[pnu_pkg::LANE_HC_ORG] = cfg.limit_organic;
  assign lx[pnu_pkg::LANE_HW_AMM] = in_data.moisture;
  assign lk[pnu_pkg::LANE_HW_AMM] = 16'(MOIST_HALF_AMMONIUM);
  assign lx[pnu_pkg::LANE_HW_NIT] = in_data.moisture;
  assign lk[pnu_pkg::LANE_HW_NIT] = 16'(MOIST_HALF_NITRATE);
  assign lx[pnu_pkg::LANE_HW_ORG] = in_data.moisture;
  assign lk[pnu_pkg::LANE_HW_ORG] = 16'(MOIST_HALF_ORGANIC);
  assign lx[pnu_pkg::LANE_HE]     = in_data.ammonium_level;
  assign lk[pnu_pkg::LANE_HE]     = cfg.ammonium_effect_half;

  for (genvar g = 0; g < pnu_pkg::NUM_LANES; g++) begin : g_lane
    pnu_hill u_hill (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .x    (lx[g]),
      .k    (lk[g]),
      .ratio(lh[g])
    );
  end

  pnu_pkg::hill_set_t hill;
  assign hill.hc_amm = lh[pnu_pkg::LANE_HC_AMM];
  assign hill.hc_nit = lh[pnu_pkg::LANE_HC_NIT];
  assign hill.hc_org = lh[pnu_pkg::LANE_HC_ORG];
  assign hill.hw_amm = lh[pnu_pkg::LANE_HW_AMM];
  assign hill.hw_nit = lh[pnu_pkg::LANE_HW_NIT];
  assign hill.hw_org = lh[pnu_pkg::LANE_HW_ORG];
  assign hill.he     = lh[pnu_pkg::LANE_HE];

  // merge the lanes into the result beat
  pnu_merge u_merge (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .cfg  (cfg),
    .hill (hill),
    .side (side_d[LAT-1]),
    .valid(out_valid),
    .beat (out_data)
  );

endmodule

// File: tb/plant_nitrogen_uptake_test.sv
// self-checking testbench for plant_nitrogen_uptake: directed table, then random phases
// holds its own uptake predictor and config copy; depends on pnu_pkg and the rtl
module plant_nitrogen_uptake_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pnu_pkg::*;

  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 400000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  in_beat_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_beat_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]        cfg_data;

  plant_nitrogen_uptake uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // copy of the config registers and results still owed
  logic [15:0] cfg_shadow [8];
  out_beat_t   uptake_due [$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // eighth-order hill ratio in q1.16
  function automatic longint unsigned hill_ratio(longint unsigned x, longint unsigned k);
    longint unsigned r;
    if (x == 0) return 0;
    r = (x >= k) ? (k << 16) / x : (x << 16) / k;
    repeat (3) r = (r * r) >> 16;
    if (x >= k) return (64'd1 << 32) / (64'd65536 + r);
    return (r << 16) / (64'd65536 + r);
  endfunction

  // demand and temperature applied, sign from t + 20
  function automatic longint temp_scaled(longint unsigned u, longint unsigned demand, int tnum);
    longint unsigned v;
    longint unsigned mag;
    longint q;
    v   = (u * demand) >> 8;
    mag = (tnum < 0) ? longint'(-tnum) : longint'(tnum);
    q   = longint'((v * mag) / longint'(TEMP_DIV));
    return (tnum < 0) ? -q : q;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic out_beat_t predict_uptake(in_beat_t b);
    longint unsigned hw, ua, un, uo, eff;
    longint ra, rn, ro;
    int tnum;
    out_beat_t r;
    tnum = int'(b.temperature) + TEMP_OFFSET;
    ua = (longint'(cfg_shadow[REG_GAIN_AMMONIUM])
          * hill_ratio(b.ammonium_level, cfg_shadow[REG_LIMIT_AMMONIUM])) >> 8;
    hw = hill_ratio(b.moisture, MOIST_HALF_AMMONIUM);
    ua = (ua * hw) >> 16;
    un = (longint'(cfg_shadow[REG_GAIN_NITRATE])
          * hill_ratio(b.nitrate_level, cfg_shadow[REG_LIMIT_NITRATE])) >> 8;
    hw = hill_ratio(b.moisture, MOIST_HALF_NITRATE);
    un = (un * hw) >> 16;
    uo = (longint'(cfg_shadow[REG_GAIN_ORGANIC])
          * hill_ratio(b.organic_level, cfg_shadow[REG_LIMIT_ORGANIC])) >> 8;
    hw = hill_ratio(b.moisture, MOIST_HALF_ORGANIC);
    uo = (uo * hw) >> 16;
    // ammonium modulates nitrate uptake
    eff = (longint'(cfg_shadow[REG_AMMONIUM_EFFECT_GAIN])
           * hill_ratio(b.ammonium_level, cfg_shadow[REG_AMMONIUM_EFFECT_HALF])) >> 8;
    un = (un * eff) >> 16;
    ra = temp_scaled(ua, b.demand_scale, tnum);
    rn = temp_scaled(un, b.demand_scale, tnum);
    ro = temp_scaled(uo, b.demand_scale, tnum);
    r.total_to_plant = clamp32(ra + rn + ro);
    r.ammonium_used  = clamp32(ra);
    r.nitrate_used   = clamp32(rn);
    r.organic_used   = clamp32(ro);
    return r;
  endfunction

  function automatic in_beat_t make_beat(logic [15:0] t, logic [15:0] m, logic [15:0] a,
                                         logic [15:0] n, logic [15:0] o, logic [15:0] d);
    in_beat_t b;
    b.temperature = t; b.moisture = m; b.ammonium_level = a;
    b.nitrate_level = n; b.organic_level = o; b.demand_scale = d;
    return b;
  endfunction

  // random level, biased toward the interesting corners of the hill ratio
  function automatic logic [15:0] pick_level(logic [15:0] limit);
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 1023));
      1: return limit + 16'($urandom_range(0, 64)) - 16'd32;
      2: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_beat_t random_beat();
    logic [15:0] t;
    t = $urandom_range(0, 3) == 0 ? 16'(-TEMP_OFFSET + $urandom_range(0, 512) - 256)
                                  : 16'($urandom);
    return make_beat(t, pick_level(16'(MOIST_HALF_AMMONIUM)),
                     pick_level(cfg_shadow[REG_LIMIT_AMMONIUM]),
                     pick_level(cfg_shadow[REG_LIMIT_NITRATE]),
                     pick_level(cfg_shadow[REG_LIMIT_ORGANIC]),
                     $urandom_range(0, 7) == 0 ? 16'hffff : 16'($urandom));
  endfunction

  // one input beat, with an optional gap; returns at the accepting edge
  task automatic send_beat(in_beat_t b, bit typed, out_beat_t typed_result);
    bit taken;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    uptake_due.push_back(typed ? typed_result : predict_uptake(b));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (uptake_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    bit taken;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    cfg_shadow[idx] = value;
  endtask

  // result stall in random bursts
  int stall_left;
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 6) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each result beat with the oldest owed one
  always @(negedge clk) begin
    out_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (uptake_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", out_data);
      end else begin
        want = uptake_due.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: total %0d/%0d amm %0d/%0d nit %0d/%0d org %0d/%0d (exp/got)",
                     want.total_to_plant, out_data.total_to_plant,
                     want.ammonium_used, out_data.ammonium_used,
                     want.nitrate_used, out_data.nitrate_used,
                     want.organic_used, out_data.organic_used);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t result;
  } vector_t;

  initial begin
    vector_t     vectors [$];
    vector_t     v;
    logic [15:0] plan [8];
    out_beat_t   zero;
    zero = '0;
    quiet = 1'b0;
    rst = 1'b1; in_valid = 1'b0; in_data = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    foreach (cfg_shadow[i]) cfg_shadow[i] = CFG_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table under reset settings
    v.typed = 1'b1; v.result = zero;
    v.beat = make_beat(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);         vectors.push_back(v);
    v.beat = make_beat(16'h0a00, 16'h0200, 16'd0, 16'd0, 16'd0, 16'h0100); vectors.push_back(v);
    v.beat = make_beat(16'h0a00, 16'h0200, 16'hffff, 16'hffff, 16'hffff, 16'd0);
    vectors.push_back(v);
    v.beat = make_beat(16'h0a00, 16'd0, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    vectors.push_back(v);
    v.beat = make_beat(16'(-TEMP_OFFSET), 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    vectors.push_back(v);
    v.typed = 1'b0;
    v.beat = make_beat(16'h7fff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    vectors.push_back(v);
    v.beat = make_beat(16'h8000, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    vectors.push_back(v);
    v.beat = make_beat(16'h1900, 16'd128, 16'd256, 16'd256, 16'd256, 16'd256);
    vectors.push_back(v);
    v.beat = make_beat(16'h1900, 16'd127, 16'd255, 16'd257, 16'd1, 16'd256);
    vectors.push_back(v);
    v.beat = make_beat(16'hec01, 16'd300, 16'd200, 16'd400, 16'd256, 16'd512);
    vectors.push_back(v);
    v.beat = make_beat(16'hebff, 16'd300, 16'd200, 16'd400, 16'd256, 16'd512);
    vectors.push_back(v);
    v.beat = make_beat(16'h0100, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    vectors.push_back(v);
    v.beat = make_beat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    vectors.push_back(v);
    v.beat = make_beat(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
    vectors.push_back(v);
    foreach (vectors[i]) send_beat(vectors[i].beat, vectors[i].typed, vectors[i].result);

    // random phases, each under its own settings
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      foreach (plan[i]) begin
        case (phase)
          0: plan[i] = 16'hffff;
          1: plan[i] = 16'h0000;
          2: plan[i] = (i < 3) ? 16'h0000 : 16'hffff;
          3: plan[i] = (i < 3) ? 16'hffff : 16'h0001;
          default: plan[i] = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                       : 16'($urandom_range(64, 1024));
        endcase
        write_reg(CFG_IDX_W'(i), plan[i]);
      end
      quiet = (phase == 5);
      for (int n = 0; n < 315; n++) begin
        // let everything drain once mid-run
        if (phase == 2 && n == 150) begin
          in_valid <= 1'b0;
          while (uptake_due.size() != 0) @(posedge clk);
        end
        send_beat(random_beat(), 1'b0, zero);
      end
    end

    in_valid <= 1'b0;
    while (uptake_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// File: plant_nitrogen_uptake.f
rtl/core/pnu_pkg.sv
rtl/core/pnu_div.sv
rtl/core/pnu_hill.sv
rtl/core/pnu_merge.sv
rtl/core/plant_nitrogen_uptake.sv
tb/plant_nitrogen_uptake_test.sv
